// ===== rtl/ffa_pkg.sv =====
`default_nettype none

package ffa_pkg;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 17;
  localparam int SUM_W  = 18;

  // Heap sizes above the address space act as the full address space.
  localparam logic [SIZE_W-1:0] HEAP_CAP   = SIZE_W'(1 << ADDR_W);
  localparam logic [SIZE_W-1:0] HEAP_RESET = SIZE_W'(65536);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_OOM    = 3'd2,
    ST_BOUNDS = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_INSERT,
    PH_DELETE,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_FIX,
    S_LAUNCH,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] len;
  } ent_t;

  // Request values for the walk: need and key are held steady for the whole walk, lim follows the configured heap size.
  typedef struct packed {
    logic [SIZE_W-1:0] need;
    logic [ADDR_W-1:0] key;
    logic [SIZE_W-1:0] lim;
  } req_t;

  // Token that travels one cell per cycle down the chain.
  typedef struct packed {
    logic              active;
    op_t               op;
    phase_t            phase;
    logic              room;
    logic [SIZE_W-1:0] prospect;
    ent_t              carry;
    status_t           status;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/ffa_cell.sv =====
`default_nettype none

module ffa_cell (
  input  logic          clk,
  input  logic          rst,
  input  ffa_pkg::req_t req,
  input  ffa_pkg::tok_t tok_in,
  input  ffa_pkg::ent_t right_in,
  output ffa_pkg::tok_t tok_out,
  output ffa_pkg::ent_t ent_out
);
  import ffa_pkg::*;

  ent_t             ent, ent_next;
  tok_t             tok, tok_next;
  logic [SUM_W-1:0] fit_end;
  logic [SUM_W-1:0] blk_end;
  logic             past_lim;

  always_comb begin
    fit_end  = SUM_W'(tok_in.prospect) + SUM_W'(req.need);
    blk_end  = SUM_W'(ent.start) + SUM_W'(ent.len);
    past_lim = SIZE_W'(ent.start) >= req.lim;
    ent_next = ent;
    tok_next = tok_in;
    if (tok_in.active) begin
      case (tok_in.phase)
        PH_SEARCH: begin
          if (tok_in.op == OP_ALLOC) begin
            if (ent.valid && past_lim) begin
              tok_next.phase  = PH_DONE;
              tok_next.status = ST_BOUNDS;
            end else if (ent.valid && fit_end > SUM_W'(ent.start)) begin
              // The gap before this block is too small: skip past it.
              tok_next.prospect = blk_end[SIZE_W-1:0];
            end else if (fit_end >= SUM_W'(req.lim)) begin
              tok_next.phase  = PH_DONE;
              tok_next.status = ST_OOM;
            end else if (!tok_in.room) begin
              tok_next.phase  = PH_DONE;
              tok_next.status = ST_FULL;
            end else begin
              // Take the new block here and push the old word to the right.
              ent_next.valid  = 1'b1;
              ent_next.start  = tok_in.prospect[ADDR_W-1:0];
              ent_next.len    = req.need;
              tok_next.carry  = ent;
              tok_next.phase  = PH_INSERT;
              tok_next.status = ST_OK;
            end
          end else begin
            if (!ent.valid || past_lim) begin
              tok_next.phase  = PH_DONE;
              tok_next.status = ST_BOUNDS;
            end else if (ent.start == req.key) begin
              ent_next        = right_in;
              tok_next.phase  = PH_DELETE;
              tok_next.status = ST_OK;
            end
          end
        end
        PH_INSERT: begin
          ent_next       = tok_in.carry;
          tok_next.carry = ent;
          if (!tok_in.carry.valid) begin
            tok_next.phase = PH_DONE;
          end
        end
        PH_DELETE: begin
          ent_next = right_in;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid  <= 1'b0;
      tok.active <= 1'b0;
    end else begin
      ent <= ent_next;
      tok <= tok_next;
    end
  end

  assign tok_out = tok;
  assign ent_out = ent;

endmodule

`default_nettype wire

// ===== rtl/ffa_ctrl.sv =====
`default_nettype none

module ffa_ctrl #(
  parameter int HEADER_SIZE = 16,
  parameter int ALIGNMENT   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ffa_pkg::SIZE_W-1:0] heap_size,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [ffa_pkg::ADDR_W-1:0] request_size,
  input  logic [ffa_pkg::ADDR_W-1:0] block_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ffa_pkg::ADDR_W-1:0] address,
  output logic [2:0]                 status,
  input  logic                       table_full,
  output ffa_pkg::req_t              req,
  output ffa_pkg::tok_t              launch,
  input  ffa_pkg::tok_t              chain_tok
);
  import ffa_pkg::*;

  // Rounding up to the alignment uses a reciprocal that is exact for every
  // value below 2^SIZE_W.
  localparam int SH      = SIZE_W + $clog2(ALIGNMENT);
  localparam int RECIP_W = SH + 1;
  localparam int PROD_W  = SIZE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << SH) + ALIGNMENT - 1) / ALIGNMENT);

  state_t            state, state_next;
  op_t               op_q;
  logic [SIZE_W-1:0] y;
  logic [PROD_W-1:0] prod;
  logic [SIZE_W:0]   quot;
  logic [SIZE_W-1:0] qa;
  logic [SIZE_W-1:0] need;
  logic [ADDR_W-1:0] key;
  logic [SIZE_W-1:0] lim;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  status_t           status_q;

  logic [ADDR_W-1:0] off;
  state_t            pre_next;
  status_t           pre_status;
  status_t           walk_status;
  logic [ADDR_W-1:0] walk_addr;
  logic [SUM_W-1:0]  walk_end;

  assign lim  = (heap_size > HEAP_CAP) ? HEAP_CAP : heap_size;
  assign quot = prod[PROD_W-1:SH];
  assign off  = block_address - ADDR_W'(HEADER_SIZE);

  assign req.need = need;
  assign req.key  = key;
  assign req.lim  = lim;

  // Checks that settle a request before any walk.
  always_comb begin
    pre_status = ST_OK;
    pre_next   = S_FINISH;
    if (op_t'(operation) == OP_ALLOC) begin
      if (request_size == '0) begin
        pre_status = ST_ZERO;
      end else begin
        pre_next = S_MUL;
      end
    end else begin
      if (block_address < ADDR_W'(HEADER_SIZE)) begin
        pre_status = ST_BOUNDS;
      end else if (SIZE_W'(off) >= lim) begin
        pre_status = ST_BOUNDS;
      end else if (off != '0) begin
        pre_next = S_LAUNCH;
      end
    end
  end

  // A token that leaves the chain still searching ran off the end of the table.
  always_comb begin
    walk_end    = SUM_W'(chain_tok.prospect) + SUM_W'(need);
    walk_status = chain_tok.status;
    walk_addr   = '0;
    if (chain_tok.phase == PH_SEARCH) begin
      if (op_q == OP_ALLOC) begin
        walk_status = (walk_end >= SUM_W'(lim)) ? ST_OOM : ST_FULL;
      end else begin
        walk_status = ST_BOUNDS;
      end
    end else if (chain_tok.status == ST_OK && op_q == OP_ALLOC) begin
      walk_addr = ADDR_W'(chain_tok.prospect + SIZE_W'(HEADER_SIZE));
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    launch     = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = pre_next;
        end
      end
      S_MUL:   state_next = S_SCALE;
      S_SCALE: state_next = S_FIX;
      S_FIX:   state_next = S_LAUNCH;
      S_LAUNCH: begin
        launch.active   = 1'b1;
        launch.op       = op_q;
        launch.phase    = PH_SEARCH;
        launch.room     = !table_full;
        launch.prospect = SIZE_W'(HEADER_SIZE);
        launch.status   = ST_OK;
        state_next      = S_WALK;
      end
      S_WALK: begin
        if (chain_tok.active) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q       <= op_t'(operation);
      y          <= SIZE_W'(request_size) + SIZE_W'(HEADER_SIZE + ALIGNMENT - 1);
      key        <= off;
      res_status <= pre_status;
      res_addr   <= '0;
    end
    if (state == S_MUL) begin
      prod <= y * RECIP;
    end
    if (state == S_SCALE) begin
      qa <= SIZE_W'(quot * ALIGNMENT);
    end
    if (state == S_FIX) begin
      need <= (y - qa >= SIZE_W'(ALIGNMENT)) ? qa + SIZE_W'(ALIGNMENT) : qa;
    end
    if (state == S_WALK && chain_tok.active) begin
      res_status <= walk_status;
      res_addr   <= walk_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      address   <= res_addr;
      status_q  <= res_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status = status_q;

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// An allocate steps through MUL, SCALE, FIX, LAUNCH, WALK and FINISH, a free
// through LAUNCH, WALK and FINISH; requests settled by the entry checks go to FINISH.
// One word at a time: the next word is taken the cycle after the result is
// registered, and each walk sends the token down the chain of MAX_BLOCKS - 1
// block cells one cell per cycle.
// Reset: heap_size 65536, table holds only the head block, no clearing pass.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int HEADER_SIZE = 16,
  parameter int ALIGNMENT   = 16,
  parameter int MAX_BLOCKS  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ffa_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [ffa_pkg::ADDR_W-1:0] request_size,
  input  logic [ffa_pkg::ADDR_W-1:0] block_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ffa_pkg::ADDR_W-1:0] address,
  output logic [2:0]                 status
);
  import ffa_pkg::*;

  // The head block never moves, so only the other entries need cells.
  localparam int NCELL = MAX_BLOCKS - 1;

  logic [SIZE_W-1:0] heap_size;
  req_t              req;
  tok_t              tok [NCELL+1];
  ent_t              ent [NCELL];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= HEAP_RESET;
    end else if (cfg_valid) begin
      heap_size <= cfg_data;
    end
  end

  ffa_ctrl #(
    .HEADER_SIZE (HEADER_SIZE),
    .ALIGNMENT   (ALIGNMENT)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .heap_size     (heap_size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .request_size  (request_size),
    .block_address (block_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .address       (address),
    .status        (status),
    .table_full    (ent[NCELL-1].valid),
    .req           (req),
    .launch        (tok[0]),
    .chain_tok     (tok[NCELL])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ent_t right;
    if (i == NCELL - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = ent[i+1];
    end

    ffa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .req      (req),
      .tok_in   (tok[i]),
      .right_in (right),
      .tok_out  (tok[i+1]),
      .ent_out  (ent[i])
    );
  end

  // Blocks stay packed toward the head and, between requests, in address
  // order without overlap.
  for (genvar i = 0; i < NCELL - 1; i++) begin : g_chk
    a_packed: assert property (@(posedge clk) disable iff (rst)
      ent[i+1].valid |-> ent[i].valid)
      else $error("block table has a hole");

    a_ordered: assert property (@(posedge clk) disable iff (rst)
      (in_ready && ent[i+1].valid) |->
        (SUM_W'(ent[i].start) + SUM_W'(ent[i].len) <= SUM_W'(ent[i+1].start)))
      else $error("blocks out of order or overlapping");
  end

  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> address == '0)
    else $error("failed request returned a nonzero address");

endmodule

`default_nettype wire
